/* rtl/srs_pkg.sv */
package srs_pkg;

    // Recording size and field widths
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_W        = 16;
    localparam int MIN_RUN_W       = 11;
    localparam int CUTOFF_W        = 15;
    localparam int SIGN_W          = 2;
    localparam int END_W           = 10;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 15;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RUN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUTOFF  = 1'b1;
    localparam logic [MIN_RUN_W-1:0]   MIN_RUN_RESET = 11'd50;
    localparam logic [CUTOFF_W-1:0]    CUTOFF_RESET  = 15'd51;

    // Sample classes; the segment sign reuses the first three codes
    localparam logic [SIGN_W-1:0] CLS_POS   = 2'd0;
    localparam logic [SIGN_W-1:0] CLS_NEG   = 2'd1;
    localparam logic [SIGN_W-1:0] CLS_ZERO  = 2'd2;
    localparam logic [SIGN_W-1:0] CLS_NONE  = 2'd3;
    localparam logic [SIGN_W-1:0] SIGN_NONE = 2'd2;

    // Result queue
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [SIGN_W-1:0] segment_sign;
        logic [END_W-1:0]  end_index;
        logic              end_of_record;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic [MIN_RUN_W-1:0] min_run;
        logic [CUTOFF_W-1:0]  cutoff;
    } cfg_t;

endpackage

/* rtl/srs_ifs.sv */
interface srs_sample_if import srs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] rate_sample;
    logic                       final_sample;

    modport source (output valid, rate_sample, final_sample, input ready);
    modport sink (input valid, rate_sample, final_sample, output ready);
endinterface

interface srs_segment_if import srs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIGN_W-1:0] segment_sign;
    logic [END_W-1:0]  end_index;
    logic              end_of_record;

    modport source (output valid, segment_sign, end_index, end_of_record, input ready);
    modport sink (input valid, segment_sign, end_index, end_of_record, output ready);
endinterface

/* rtl/srs_core.sv */
module srs_core import srs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic signed [SAMPLE_W-1:0] rate_sample,
    input  logic                       final_sample,
    input  cfg_t                       cfg,
    output push_t                      push
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W = LEN_W + MIN_RUN_W;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SAMPLES);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    logic [SIGN_W-1:0] class_reg, class_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SIGN_W-1:0] last_reg, last_next;

    logic signed [SAMPLE_W:0] sample_ext;
    logic signed [SAMPLE_W:0] cut_pos;
    logic signed [SAMPLE_W:0] cut_neg;
    logic [SIGN_W-1:0]        cls;
    logic                     changed;
    logic                     rep_old;
    logic                     rep_new;
    logic [SIGN_W-1:0]        last_after_old;
    logic [LEN_W-1:0]         len_upd;
    result_t                  res_old;
    result_t                  res_new;
    result_t                  res_empty;

    // Low bits of a sample index, zero-extended for short recordings
    function automatic logic [END_W-1:0] to_end(input logic [IDX_W-1:0] i);
        logic [IDX_W+END_W-1:0] w;
        w = {{END_W{1'b0}}, i};
        return w[END_W-1:0];
    endfunction

    // Classify the sample against the symmetric cutoff
    always_comb
    begin
        sample_ext = {rate_sample[SAMPLE_W-1], rate_sample};
        cut_pos    = {2'b00, cfg.cutoff};
        cut_neg    = -cut_pos;
        if (sample_ext > cut_pos)
            cls = CLS_POS;
        else if (sample_ext < cut_neg)
            cls = CLS_NEG;
        else
            cls = CLS_ZERO;
    end

    // Decide which runs get reported by this beat
    always_comb
    begin
        changed = (cls != class_reg);
        rep_old = changed
                  && (CMP_W'(len_reg) >= CMP_W'(cfg.min_run))
                  && ((class_reg == CLS_POS) || (class_reg == CLS_NEG))
                  && (class_reg != last_reg);
        last_after_old = rep_old ? class_reg : last_reg;

        if (changed)
            len_upd = LEN_ONE;
        else if (len_reg < LEN_MAX)
            len_upd = len_reg + LEN_ONE;
        else
            len_upd = len_reg;

        rep_new = final_sample
                  && (CMP_W'(len_upd) >= CMP_W'(cfg.min_run))
                  && ((cls == CLS_POS) || (cls == CLS_NEG))
                  && (cls != last_after_old);

        res_old   = '{segment_sign: class_reg, end_index: to_end(idx_reg - IDX_ONE),
                      end_of_record: 1'b0};
        res_new   = '{segment_sign: cls, end_index: to_end(idx_reg), end_of_record: 1'b1};
        res_empty = '{segment_sign: SIGN_NONE, end_index: '0, end_of_record: 1'b1};
    end

    // Assemble up to two results for the queue
    always_comb
    begin
        push.count  = 2'd0;
        push.first  = res_old;
        push.second = res_new;
        if (take)
        begin
            if (final_sample)
            begin
                push.count = 2'd1;
                if (rep_old && rep_new)
                    push.count = 2'd2;
                else if (rep_old)
                    push.first.end_of_record = 1'b1;
                else if (rep_new)
                    push.first = res_new;
                else
                    push.first = res_empty;
            end
            else if (rep_old)
            begin
                push.count = 2'd1;
            end
        end
    end

    // Advance the run state; the final sample returns it to reset
    always_comb
    begin
        class_next = class_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        last_next  = last_reg;
        if (take)
        begin
            if (final_sample)
            begin
                class_next = CLS_NONE;
                len_next   = '0;
                idx_next   = '0;
                last_next  = CLS_NONE;
            end
            else
            begin
                class_next = cls;
                len_next   = len_upd;
                last_next  = last_after_old;
                if (idx_reg < IDX_MAX)
                    idx_next = idx_reg + IDX_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= CLS_NONE;
            len_reg   <= '0;
            idx_reg   <= '0;
            last_reg  <= CLS_NONE;
        end
        else
        begin
            class_reg <= class_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

endmodule

/* rtl/srs_outq.sv */
module srs_outq import srs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output result_t head,
    output logic    not_empty,
    output logic    room
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    result_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= ROOM_MAX);

    // Move pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // Store results; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + PTR_ONE] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/sign_run_segmenter_top.sv */
// A result is written into the result queue on the sample beat that causes it.
// One sample beat per cycle is taken while the result queue has room;
// a final sample that reports two runs pushes both results into the queue together.
// Sample ready is high while the four-entry result queue has at least two free entries.
// Reset (rst_n, asynchronous, active low) empties the queue, clears the run state
// and loads min_run = 50 and cutoff = 51; the block takes a beat right after.
module sign_run_segmenter_top import srs_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    srs_sample_if.sink             samples,
    srs_segment_if.source          segments
);

    cfg_t    cfg_reg, cfg_next;
    push_t   push;
    result_t head;
    logic    take;
    logic    pop;
    logic    room;
    logic    not_empty;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_MIN_RUN: cfg_next.min_run = cfg_data[MIN_RUN_W-1:0];
                CFG_CUTOFF:  cfg_next.cutoff  = cfg_data[CUTOFF_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_run <= MIN_RUN_RESET;
            cfg_reg.cutoff  <= CUTOFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Beat handshakes
    assign take = samples.valid && samples.ready;
    assign pop  = segments.valid && segments.ready;

    assign samples.ready          = room;
    assign segments.valid         = not_empty;
    assign segments.segment_sign  = head.segment_sign;
    assign segments.end_index     = head.end_index;
    assign segments.end_of_record = head.end_of_record;

    srs_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .rate_sample  (samples.rate_sample),
        .final_sample (samples.final_sample),
        .cfg          (cfg_reg),
        .push         (push)
    );

    srs_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

endmodule

/* rtl/srs_checker.sv */
module srs_checker import srs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              seg_valid,
    input logic              seg_ready,
    input logic [SIGN_W-1:0] seg_sign,
    input logic [END_W-1:0]  seg_end_index,
    input logic              seg_eor
);

    logic [SIGN_W-1:0] prev_sign_reg;
    logic              prev_open_reg;

    // Track the sign of the last segment delivered in this record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sign_reg <= SIGN_NONE;
            prev_open_reg <= 1'b0;
        end
        else if (seg_valid && seg_ready)
        begin
            if (seg_eor)
            begin
                prev_open_reg <= 1'b0;
            end
            else if (seg_sign != SIGN_NONE)
            begin
                prev_open_reg <= 1'b1;
                prev_sign_reg <= seg_sign;
            end
        end
    end

    // Stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && !seg_ready |=> seg_valid && $stable(seg_sign)
            && $stable(seg_end_index) && $stable(seg_eor))
        else $error("result beat changed while stalled");

    // An empty end marker closes the record and carries index zero
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_sign == SIGN_NONE |-> seg_eor && seg_end_index == '0)
        else $error("end marker malformed");

    // Reported segments within one record alternate in sign
    a_alternate: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready && prev_open_reg && seg_sign != SIGN_NONE
            |-> seg_sign != prev_sign_reg)
        else $error("segment repeats the previous sign");

endmodule

bind sign_run_segmenter_top srs_checker u_srs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .seg_valid     (segments.valid),
    .seg_ready     (segments.ready),
    .seg_sign      (segments.segment_sign),
    .seg_end_index (segments.end_index),
    .seg_eor       (segments.end_of_record)
);
